>>> hw/rtl/lrfs_pkg.sv
// shared types and constants for the lcd rectangle fill sequencer
package lrfs_pkg;

  // panel geometry
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 128;

  // clipped width / height counts and total pixel count
  localparam int WDIM_W = $clog2(PANEL_WIDTH + 1);
  localparam int HDIM_W = $clog2(PANEL_HEIGHT + 1);
  localparam int PIX_W  = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);

  localparam logic [15:0] PANEL_W16 = 16'(PANEL_WIDTH);
  localparam logic [15:0] PANEL_H16 = 16'(PANEL_HEIGHT);

  // two-entry queues, depth a power of two so the pointers wrap on their own
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

  // input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_PULL  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_IDLE   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // command classes from the front
  localparam logic [1:0] CLS_PULL  = 2'd0;
  localparam logic [1:0] CLS_START = 2'd1;
  localparam logic [1:0] CLS_BAD   = 2'd2;

  // panel command bytes
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  typedef struct packed {
    logic [1:0]       cls;
    logic [15:0]      x_start;
    logic [15:0]      x_end;
    logic [15:0]      y_start;
    logic [15:0]      y_end;
    logic [15:0]      color;
    logic [PIX_W-1:0] pix;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic [1:0] kind;
    logic       last_byte;
  } res_t;

endpackage

>>> hw/rtl/lrfs_front.sv
// front: accepts requests, clips them to the panel and queues them for the back
module lrfs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_opcode,
  input  logic [15:0]       in_rect_x,
  input  logic [15:0]       in_rect_y,
  input  logic [15:0]       in_rect_w,
  input  logic [15:0]       in_rect_h,
  input  logic [15:0]       in_fill_color,
  output logic              cmd_valid,
  output lrfs_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  lrfs_pkg::cmd_t                  q_r [lrfs_pkg::Q_DEPTH];
  logic [lrfs_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lrfs_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lrfs_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                            wr_en;
  logic                            bad;
  logic [16:0]                     x_sum, y_sum;
  logic [lrfs_pkg::WDIM_W-1:0]     w_clip;
  logic [lrfs_pkg::HDIM_W-1:0]     h_clip;
  logic [lrfs_pkg::WDIM_W+lrfs_pkg::HDIM_W-1:0] prod;
  lrfs_pkg::cmd_t                  cmd_in;

  assign full  = (cnt_r == lrfs_pkg::Q_FULL_CNT);
  assign wr_en = push && !full;

  // classify and clip
  always_comb begin
    bad = (in_rect_x >= lrfs_pkg::PANEL_W16) || (in_rect_y >= lrfs_pkg::PANEL_H16) ||
          (in_rect_w == 16'd0) || (in_rect_h == 16'd0);
    x_sum = {1'b0, in_rect_x} + {1'b0, in_rect_w};
    y_sum = {1'b0, in_rect_y} + {1'b0, in_rect_h};
    if (x_sum > {1'b0, lrfs_pkg::PANEL_W16}) begin
      w_clip = lrfs_pkg::WDIM_W'(lrfs_pkg::PANEL_W16 - in_rect_x);
    end else begin
      w_clip = in_rect_w[lrfs_pkg::WDIM_W-1:0];
    end
    if (y_sum > {1'b0, lrfs_pkg::PANEL_H16}) begin
      h_clip = lrfs_pkg::HDIM_W'(lrfs_pkg::PANEL_H16 - in_rect_y);
    end else begin
      h_clip = in_rect_h[lrfs_pkg::HDIM_W-1:0];
    end
    prod = (lrfs_pkg::WDIM_W+lrfs_pkg::HDIM_W)'(w_clip) *
           (lrfs_pkg::WDIM_W+lrfs_pkg::HDIM_W)'(h_clip);

    cmd_in.x_start = in_rect_x;
    cmd_in.x_end   = in_rect_x + 16'(w_clip) - 16'd1;
    cmd_in.y_start = in_rect_y;
    cmd_in.y_end   = in_rect_y + 16'(h_clip) - 16'd1;
    cmd_in.color   = in_fill_color;
    cmd_in.pix     = prod[lrfs_pkg::PIX_W-1:0];
    if (in_opcode == lrfs_pkg::OP_PULL) begin
      cmd_in.cls = lrfs_pkg::CLS_PULL;
    end else if (bad) begin
      cmd_in.cls = lrfs_pkg::CLS_BAD;
    end else begin
      cmd_in.cls = lrfs_pkg::CLS_START;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + lrfs_pkg::Q_CNT_W'(wr_en) - lrfs_pkg::Q_CNT_W'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  // a pop only ever takes a queued entry
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cnt_r != '0)
    else $error("command queue popped while empty");

  // a blocked push leaves the fill level alone unless the back pops
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full && !cmd_pop) |=> $stable(cnt_r))
    else $error("command queue level changed on a blocked push");

endmodule

>>> hw/rtl/lrfs_back.sv
// back: fill sequencer state and the result queue
module lrfs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  lrfs_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           empty,
  input  logic           pop,
  output lrfs_pkg::res_t res_head
);

  // header steps, pixel phase after the last one
  localparam logic [3:0] ST_CASET = 4'd0;
  localparam logic [3:0] ST_XS_HI = 4'd1;
  localparam logic [3:0] ST_XS_LO = 4'd2;
  localparam logic [3:0] ST_XE_HI = 4'd3;
  localparam logic [3:0] ST_XE_LO = 4'd4;
  localparam logic [3:0] ST_RASET = 4'd5;
  localparam logic [3:0] ST_YS_HI = 4'd6;
  localparam logic [3:0] ST_YS_LO = 4'd7;
  localparam logic [3:0] ST_YE_HI = 4'd8;
  localparam logic [3:0] ST_YE_LO = 4'd9;
  localparam logic [3:0] ST_RAMWR = 4'd10;
  localparam logic [3:0] ST_PIXEL = 4'd11;

  logic                          busy_r, busy_nxt;
  logic [3:0]                    step_r, step_nxt;
  logic [lrfs_pkg::PIX_W-1:0]    pix_r, pix_nxt, pix_dec;
  logic                          low_r, low_nxt;
  logic [15:0]                   xs_r, xs_nxt, xe_r, xe_nxt;
  logic [15:0]                   ys_r, ys_nxt, ye_r, ye_nxt;
  logic [15:0]                   color_r, color_nxt;

  lrfs_pkg::res_t                res;
  lrfs_pkg::res_t                oq_r [lrfs_pkg::Q_DEPTH];
  logic [lrfs_pkg::Q_PTR_W-1:0]  oq_wr_r, oq_rd_r;
  logic [lrfs_pkg::Q_CNT_W-1:0]  oq_cnt_r;
  logic                          take, out_fire;

  assign take     = cmd_valid && (oq_cnt_r != lrfs_pkg::Q_FULL_CNT);
  assign cmd_pop  = take;
  assign empty    = (oq_cnt_r == '0);
  assign out_fire = pop && !empty;
  assign res_head = oq_r[oq_rd_r];

  always_comb begin
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    pix_nxt   = pix_r;
    low_nxt   = low_r;
    xs_nxt    = xs_r;
    xe_nxt    = xe_r;
    ys_nxt    = ys_r;
    ye_nxt    = ye_r;
    color_nxt = color_r;
    pix_dec   = (pix_r != '0) ? pix_r - 1'b1 : pix_r;
    res       = '{out_byte: 8'd0, is_command: 1'b0, kind: lrfs_pkg::KIND_IDLE,
                  last_byte: 1'b0};
    case (cmd.cls)
      lrfs_pkg::CLS_BAD: begin
        res.kind = lrfs_pkg::KIND_REJECT;
      end
      lrfs_pkg::CLS_START: begin
        if (busy_r) begin
          res.kind = lrfs_pkg::KIND_REJECT;
        end else begin
          res.kind  = lrfs_pkg::KIND_ACCEPT;
          busy_nxt  = 1'b1;
          step_nxt  = ST_CASET;
          low_nxt   = 1'b0;
          pix_nxt   = cmd.pix;
          xs_nxt    = cmd.x_start;
          xe_nxt    = cmd.x_end;
          ys_nxt    = cmd.y_start;
          ye_nxt    = cmd.y_end;
          color_nxt = cmd.color;
        end
      end
      default: begin
        if (busy_r) begin
          res.kind = lrfs_pkg::KIND_BYTE;
          if (step_r != ST_PIXEL) begin
            step_nxt = step_r + 4'd1;
            case (step_r)
              ST_CASET: begin
                res.out_byte   = lrfs_pkg::CMD_CASET;
                res.is_command = 1'b1;
              end
              ST_XS_HI: res.out_byte = xs_r[15:8];
              ST_XS_LO: res.out_byte = xs_r[7:0];
              ST_XE_HI: res.out_byte = xe_r[15:8];
              ST_XE_LO: res.out_byte = xe_r[7:0];
              ST_RASET: begin
                res.out_byte   = lrfs_pkg::CMD_RASET;
                res.is_command = 1'b1;
              end
              ST_YS_HI: res.out_byte = ys_r[15:8];
              ST_YS_LO: res.out_byte = ys_r[7:0];
              ST_YE_HI: res.out_byte = ye_r[15:8];
              ST_YE_LO: res.out_byte = ye_r[7:0];
              default: begin
                res.out_byte   = lrfs_pkg::CMD_RAMWR;
                res.is_command = 1'b1;
              end
            endcase
          end else if (!low_r) begin
            low_nxt      = 1'b1;
            res.out_byte = color_r[15:8];
          end else begin
            low_nxt      = 1'b0;
            pix_nxt      = pix_dec;
            res.out_byte = color_r[7:0];
            if (pix_dec == '0) begin
              busy_nxt      = 1'b0;
              step_nxt      = ST_CASET;
              res.last_byte = 1'b1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ST_CASET;
      pix_r  <= '0;
      low_r  <= 1'b0;
    end else if (take) begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      pix_r  <= pix_nxt;
      low_r  <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      xs_r    <= xs_nxt;
      xe_r    <= xe_nxt;
      ys_r    <= ys_nxt;
      ye_r    <= ye_nxt;
      color_r <= color_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (take) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (out_fire) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + lrfs_pkg::Q_CNT_W'(take) - lrfs_pkg::Q_CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  // the final byte of a fill leaves the sequencer idle
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res.last_byte) |=> !busy_r && step_r == ST_CASET)
    else $error("sequencer still busy after last byte");

  // pixel phase always has pixels left to send
  a_pix_left: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == ST_PIXEL) |-> pix_r != '0)
    else $error("pixel phase with no pixels left");

  // an accepted start only happens from idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res.kind == lrfs_pkg::KIND_ACCEPT) |-> !busy_r)
    else $error("start accepted while busy");

endmodule

>>> hw/rtl/lcd_rect_fill_sequencer.sv
// top level of the lcd rectangle fill sequencer: front, command queue and back
// a request beat is registered in the command queue, then its result in the result queue, before the ports show it
// throughput: one beat per cycle while a request is queued and the result queue has room
// both sides are two-entry queues, which absorb a stall on either side until they fill
// reset is synchronous, active low: queues emptied, sequencer idle, no fill running
module lcd_rect_fill_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // request side
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic [15:0] in_rect_x,
  input  logic [15:0] in_rect_y,
  input  logic [15:0] in_rect_w,
  input  logic [15:0] in_rect_h,
  input  logic [15:0] in_fill_color,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_is_command,
  output logic [1:0]  out_kind,
  output logic        out_last_byte
);

  // classified, clipped request waiting for the back
  logic           cmd_valid;
  lrfs_pkg::cmd_t cmd;
  logic           cmd_pop;
  // oldest result beat
  lrfs_pkg::res_t res_head;

  // front clips the rectangle and computes the pixel count
  lrfs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_opcode     (in_opcode),
    .in_rect_x     (in_rect_x),
    .in_rect_y     (in_rect_y),
    .in_rect_w     (in_rect_w),
    .in_rect_h     (in_rect_h),
    .in_fill_color (in_fill_color),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // back walks the header bytes and the pixel stream
  lrfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res_head  (res_head)
  );

  // result fields straight from the head of the result queue
  assign out_byte       = res_head.out_byte;
  assign out_is_command = res_head.is_command;
  assign out_kind       = res_head.kind;
  assign out_last_byte  = res_head.last_byte;

endmodule
